// File: rtl/ptb_pkg.sv
// Shared types and constants for the periodic timer bank.
`timescale 1ns / 1ps

package ptb_pkg;

  localparam int NUM_TIMERS_DEF = 4;
  localparam int CNT_W          = 32;
  localparam int MASK_W         = 4;
  localparam int IN_DATA_W      = 72;
  localparam int OUT_DATA_W     = 8;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Input tdata layout, last field in the lowest bits.
  typedef struct packed {
    logic             pad;
    logic [CNT_W-1:0] period;
    logic [CNT_W-1:0] start_count;
    logic             auto_reload;
    logic             run;
    logic             in_use;
    logic [1:0]       timer_index;
    logic [1:0]       req_type;
  } req_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the incoming request
    logic exec;   // apply the captured request and load the result register
  } ptb_cmd_t;

endpackage

// File: rtl/ptb_ctrl.sv
// Controller: request handshake, sequencing and result valid.
`timescale 1ns / 1ps

module ptb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output ptb_pkg::ptb_cmd_t cmd
);
  import ptb_pkg::*;

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r, in_tready_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   accept, exec;

  assign accept = in_tvalid && in_tready_r;
  // The result register may be reloaded once it is empty or being drained.
  assign exec   = (state_r == ST_EXEC) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt      = state_r;
    in_tready_nxt  = in_tready_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt     = ST_EXEC;
          in_tready_nxt = 1'b0;
        end else begin
          in_tready_nxt = 1'b1;
        end
      end
      ST_EXEC: begin
        if (exec) begin
          state_nxt      = ST_IDLE;
          in_tready_nxt  = 1'b1;
          out_tvalid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt     = ST_IDLE;
        in_tready_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      in_tready_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      in_tready_r  <= in_tready_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;
  assign cmd.load   = accept;
  assign cmd.exec   = exec;

endmodule

// File: rtl/ptb_datapath.sv
// Datapath: timer state, per-timer count and compare, result register.
`timescale 1ns / 1ps

module ptb_datapath #(
  parameter int NumTimers = ptb_pkg::NUM_TIMERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ptb_pkg::ptb_cmd_t               cmd,
  input  logic [ptb_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic [ptb_pkg::MASK_W-1:0]      fire_mask,
  output logic [ptb_pkg::MASK_W-1:0]      running_mask,
  output logic                            exec_is_tick
);
  import ptb_pkg::*;

  req_t             req_r;
  logic [CNT_W-1:0] count_r   [NumTimers];
  logic [CNT_W-1:0] count_nxt [NumTimers];
  logic [CNT_W-1:0] period_r  [NumTimers];
  logic [CNT_W-1:0] period_nxt[NumTimers];
  logic [NumTimers-1:0] used_r, used_nxt;
  logic [NumTimers-1:0] run_r, run_nxt;
  logic [NumTimers-1:0] reload_r, reload_nxt;
  logic [NumTimers-1:0] fire;
  logic [NumTimers-1:0] active_nxt;
  logic [NumTimers+MASK_W-1:0] fire_ext;
  logic [NumTimers+MASK_W-1:0] active_ext;
  logic [MASK_W-1:0] fire_mask_r, running_mask_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req_t'(in_tdata);
    end
  end

  // Every timer has its own incrementer and period compare.
  always_comb begin
    logic [CNT_W-1:0] cnt_inc;
    logic             sel;
    for (int t = 0; t < NumTimers; t++) begin
      cnt_inc       = count_r[t] + CNT_W'(1);
      sel           = (32'(req_r.timer_index) == t);
      count_nxt[t]  = count_r[t];
      period_nxt[t] = period_r[t];
      used_nxt[t]   = used_r[t];
      run_nxt[t]    = run_r[t];
      reload_nxt[t] = reload_r[t];
      fire[t]       = 1'b0;
      case (req_r.req_type)
        REQ_TICK: begin
          if (used_r[t] && run_r[t]) begin
            if ((period_r[t] != '0) && (cnt_inc == period_r[t])) begin
              fire[t]      = 1'b1;
              count_nxt[t] = '0;
              run_nxt[t]   = reload_r[t];
            end else begin
              count_nxt[t] = cnt_inc;
            end
          end
        end
        REQ_WRITE: begin
          if (sel) begin
            used_nxt[t]   = req_r.in_use;
            run_nxt[t]    = req_r.run;
            reload_nxt[t] = req_r.auto_reload;
            count_nxt[t]  = req_r.start_count;
            period_nxt[t] = req_r.period;
          end
        end
        REQ_CLEAR: begin
          if (sel) begin
            count_nxt[t] = '0;
          end
        end
        default: begin
        end
      endcase
      active_nxt[t] = used_nxt[t] && run_nxt[t];
    end
  end

  // Only the low timers appear in the masks; pad for banks smaller than the mask.
  assign fire_ext   = {{MASK_W{1'b0}}, fire};
  assign active_ext = {{MASK_W{1'b0}}, active_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < NumTimers; t++) begin
        count_r[t]  <= '0;
        period_r[t] <= '0;
      end
      used_r   <= '0;
      run_r    <= '0;
      reload_r <= '0;
    end else if (cmd.exec) begin
      for (int t = 0; t < NumTimers; t++) begin
        count_r[t]  <= count_nxt[t];
        period_r[t] <= period_nxt[t];
      end
      used_r   <= used_nxt;
      run_r    <= run_nxt;
      reload_r <= reload_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      fire_mask_r    <= fire_ext[MASK_W-1:0];
      running_mask_r <= active_ext[MASK_W-1:0];
    end
  end

  assign fire_mask    = fire_mask_r;
  assign running_mask = running_mask_r;
  assign exec_is_tick = (req_r.req_type == REQ_TICK);

endmodule

// File: rtl/periodic_timer_bank.sv
// Periodic timer bank: one result per request, with the fire and running masks.
// An accepted request is registered, then executed in the EXEC state into the result register.
// A new request is accepted only after the previous one has been executed.
// Execution stalls while an earlier result waits in the output register.
// Reset (synchronous, rst_n low) clears all timers and drops tready and tvalid.
`timescale 1ns / 1ps

module periodic_timer_bank #(
  parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // req_type[1:0], timer_index[3:2], in_use[4], run[5], auto_reload[6],
  // start_count[38:7], period[70:39], zero fill [71]
  input  logic [ptb_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // fire_mask[3:0], running_mask[7:4]
  output logic [ptb_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import ptb_pkg::*;

  ptb_cmd_t          cmd;
  logic [MASK_W-1:0] fire_mask, running_mask;
  logic              exec_is_tick;

  ptb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  ptb_datapath #(
    .NumTimers (NUM_TIMERS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_tdata     (in_tdata),
    .fire_mask    (fire_mask),
    .running_mask (running_mask),
    .exec_is_tick (exec_is_tick)
  );

  assign out_tdata = {running_mask, fire_mask};

`ifndef SYNTHESIS
  // A request is accepted only when no other one is in flight.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in flight");

  // Executing a request always leaves a valid result behind.
  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_tvalid)
    else $error("executed request produced no result");

  // Only a tick can fire timers.
  a_fire_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && !exec_is_tick) |=> (fire_mask == '0))
    else $error("fire mask set on a non-tick request");
`endif

endmodule
